// ===== rtl/ppp_pkg.sv =====
//------------------------------------------------------------------------------
// ppp_pkg
// shared types, constants and register indexes of the projection unit
//------------------------------------------------------------------------------
`default_nettype none
package ppp_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned RotFrac  = 16;
  localparam int unsigned EntryW   = RotFrac + 2;
  localparam int unsigned RowW     = 3 * EntryW;
  localparam int unsigned ProdW    = CoordW + EntryW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned CamW     = SumW - RotFrac + 1;
  localparam int unsigned NumW     = CamW + CoordW + 1;
  localparam int unsigned MagW     = NumW;
  localparam int unsigned DenW     = CamW;
  localparam int unsigned OutW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROT_ROW0  = 3'd0,
    REG_ROT_ROW1  = 3'd1,
    REG_ROT_ROW2  = 3'd2,
    REG_TRANS_X   = 3'd3,
    REG_TRANS_Y   = 3'd4,
    REG_TRANS_Z   = 3'd5,
    REG_FOCAL     = 3'd6,
    REG_PRINCIPAL = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CamW-1:0] cam_x;
    logic signed [CamW-1:0] cam_y;
    logic signed [CamW-1:0] cam_z;
  } cam_point_t;

  typedef struct packed {
    logic                   neg;
    logic                   zero;
    logic                   z_neg;
    logic [MagW-1:0]        mag;
    logic [DenW-1:0]        den;
    logic [MagW-1:0]        rem;
    logic [MagW-1:0]        quo;
    logic                   num_neg;
    logic signed [CoordW:0] ctr;
  } div_lane_t;

endpackage
`default_nettype wire

// ===== rtl/ppp_front.sv =====
//------------------------------------------------------------------------------
// ppp_front
// rotation and translation into camera space, two register stages
//------------------------------------------------------------------------------
`default_nettype none
module ppp_front (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [ppp_pkg::CoordW-1:0]     px_i,
  input  wire  signed [ppp_pkg::CoordW-1:0]     py_i,
  input  wire  signed [ppp_pkg::CoordW-1:0]     pz_i,
  input  wire         [ppp_pkg::RowW-1:0]       rot_row0_i,
  input  wire         [ppp_pkg::RowW-1:0]       rot_row1_i,
  input  wire         [ppp_pkg::RowW-1:0]       rot_row2_i,
  input  wire  signed [ppp_pkg::CoordW-1:0]     trans_x_i,
  input  wire  signed [ppp_pkg::CoordW-1:0]     trans_y_i,
  input  wire  signed [ppp_pkg::CoordW-1:0]     trans_z_i,
  output logic                                  cam_valid_o,
  input  wire                                   cam_stall_i,
  output ppp_pkg::cam_point_t                   cam_o
);

  logic signed [ppp_pkg::ProdW-1:0] prod_q [9];
  logic signed [ppp_pkg::ProdW-1:0] prod_d [9];
  logic s1_valid_q;
  logic s2_valid_q;
  ppp_pkg::cam_point_t cam_q, cam_d;
  logic advance1, advance2;
  logic [ppp_pkg::RowW-1:0] rows [3];
  logic signed [ppp_pkg::CoordW-1:0] pts [3];
  logic signed [ppp_pkg::CoordW-1:0] trs [3];
  logic signed [ppp_pkg::CamW-1:0] cams [3];

  assign advance2 = !s2_valid_q || !cam_stall_i;
  assign advance1 = !s1_valid_q || advance2;
  assign in_stall = !advance1;

  assign rows[0] = rot_row0_i;
  assign rows[1] = rot_row1_i;
  assign rows[2] = rot_row2_i;
  assign pts[0]  = px_i;
  assign pts[1]  = py_i;
  assign pts[2]  = pz_i;
  assign trs[0]  = trans_x_i;
  assign trs[1]  = trans_y_i;
  assign trs[2]  = trans_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r*3+c] = ppp_pkg::ProdW'(
          $signed(rows[r][c*ppp_pkg::EntryW +: ppp_pkg::EntryW]) * pts[c]);
      end
    end
  end

  always_comb begin
    logic signed [ppp_pkg::SumW-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = ppp_pkg::SumW'(prod_q[r*3]) + ppp_pkg::SumW'(prod_q[r*3+1])
          + ppp_pkg::SumW'(prod_q[r*3+2])
          + ppp_pkg::SumW'(1 << (ppp_pkg::RotFrac - 1));
      cams[r] = ppp_pkg::CamW'(acc >>> ppp_pkg::RotFrac) + ppp_pkg::CamW'(trs[r]);
    end
    cam_d.cam_x = cams[0];
    cam_d.cam_y = cams[1];
    cam_d.cam_z = cams[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (advance1) s1_valid_q <= in_valid;
      if (advance2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance1 && in_valid) prod_q <= prod_d;
    if (advance2 && s1_valid_q) cam_q <= cam_d;
  end

  assign cam_valid_o = s2_valid_q;
  assign cam_o       = cam_q;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && cam_stall_i |=> s2_valid_q && $stable(cam_q))
    else $error("camera point lost under stall");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && advance2 |=> s2_valid_q)
    else $error("stage one item dropped");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall |-> s1_valid_q && s2_valid_q)
    else $error("stall with free stage");
`endif

endmodule
`default_nettype wire

// ===== rtl/ppp_queue.sv =====
//------------------------------------------------------------------------------
// ppp_queue
// short fifo of camera points between front and back
//------------------------------------------------------------------------------
`default_nettype none
module ppp_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   wr_valid_i,
  output logic                  wr_stall_o,
  input  ppp_pkg::cam_point_t   wr_data_i,
  output logic                  rd_valid_o,
  input  wire                   rd_stall_i,
  output ppp_pkg::cam_point_t   rd_data_o
);

  ppp_pkg::cam_point_t mem_q [ppp_pkg::QueueDepth];
  logic [ppp_pkg::QueuePtrW-1:0] wp_q, rp_q;
  logic [ppp_pkg::QueuePtrW:0]   cnt_q, cnt_d;
  logic push, pop;

  assign wr_stall_o = (cnt_q == (ppp_pkg::QueuePtrW+1)'(ppp_pkg::QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && !wr_stall_o;
  assign pop  = rd_valid_o && !rd_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

`ifndef NO_ASSERTIONS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (ppp_pkg::QueuePtrW+1)'(ppp_pkg::QueueDepth))
    else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) == cnt_q[ppp_pkg::QueuePtrW-1:0])
    else $error("queue pointers disagree with count");
  a_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push not counted");
`endif

endmodule
`default_nettype wire

// ===== rtl/ppp_back.sv =====
//------------------------------------------------------------------------------
// ppp_back
// projection: scale by focal, pipelined restoring divide by depth, round,
// add principal point and saturate; one quotient bit per stage
//------------------------------------------------------------------------------
`default_nettype none
module ppp_back (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cam_valid_i,
  output logic                               cam_stall_o,
  input  ppp_pkg::cam_point_t                cam_i,
  input  wire  [2*ppp_pkg::CoordW-1:0]       focal_i,
  input  wire  [2*ppp_pkg::CoordW-1:0]       principal_i,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [ppp_pkg::OutW-1:0]    img_u_o,
  output logic signed [ppp_pkg::OutW-1:0]    img_v_o,
  output logic                               depth_zero_o,
  output logic                               depth_negative_o
);

  localparam int unsigned NStage = ppp_pkg::MagW + 3;

  typedef struct packed {
    logic signed [ppp_pkg::CamW-1:0] cam;
    logic [ppp_pkg::CoordW-1:0] f;
    logic [ppp_pkg::CoordW-1:0] c;
  } mul_in_t;

  logic v_q [NStage];
  logic adv [NStage];
  ppp_pkg::div_lane_t lane_q [1:NStage-2][2];
  ppp_pkg::div_lane_t lane_d [1:NStage-2][2];
  mul_in_t mi_q [2];
  logic signed [ppp_pkg::CamW-1:0] z_q;
  logic signed [ppp_pkg::OutW-1:0] res_q [2];
  logic signed [ppp_pkg::OutW-1:0] res_d [2];
  logic zero_q, zneg_q;

  // stage 0: latch operands, stage 1: multiply, stages 2..: divide bits, last: finish
  always_comb begin
    adv[NStage-1] = !v_q[NStage-1] || !out_stall;
    for (int s = NStage - 2; s >= 0; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end
  end
  assign cam_stall_o = !adv[0];

  always_comb begin
    logic signed [ppp_pkg::NumW-1:0] num;
    logic [ppp_pkg::MagW:0] trial;
    logic [ppp_pkg::MagW-1:0] half;
    logic [ppp_pkg::MagW:0] q_ext;
    logic signed [ppp_pkg::MagW+2:0] sq;
    for (int s = 1; s < NStage - 1; s++) begin
      lane_d[s][0] = lane_q[s][0];
      lane_d[s][1] = lane_q[s][1];
    end
    for (int l = 0; l < 2; l++) begin
      num = ppp_pkg::NumW'(mi_q[l].cam) * $signed({1'b0, mi_q[l].f});
      lane_d[1][l].num_neg = num[ppp_pkg::NumW-1];
      lane_d[1][l].zero    = (z_q == '0);
      lane_d[1][l].z_neg   = z_q[ppp_pkg::CamW-1];
      lane_d[1][l].neg     = num[ppp_pkg::NumW-1] ^ z_q[ppp_pkg::CamW-1];
      lane_d[1][l].den     = z_q[ppp_pkg::CamW-1] ? ppp_pkg::DenW'(-z_q)
                                                  : ppp_pkg::DenW'(z_q);
      half = ppp_pkg::MagW'(lane_d[1][l].den >> 1);
      lane_d[1][l].mag = (num[ppp_pkg::NumW-1] ? ppp_pkg::MagW'(-num)
                                               : ppp_pkg::MagW'(num)) + half;
      lane_d[1][l].rem = '0;
      lane_d[1][l].quo = '0;
      lane_d[1][l].ctr = $signed({1'b0, mi_q[l].c});
      for (int s = 2; s < NStage - 1; s++) begin
        lane_d[s][l] = lane_q[s-1][l];
        trial = {lane_q[s-1][l].rem, lane_q[s-1][l].mag[ppp_pkg::MagW-1]}
              - (ppp_pkg::MagW+1)'(lane_q[s-1][l].den);
        lane_d[s][l].mag = lane_q[s-1][l].mag << 1;
        if (!trial[ppp_pkg::MagW]) begin
          lane_d[s][l].rem = trial[ppp_pkg::MagW-1:0];
          lane_d[s][l].quo = {lane_q[s-1][l].quo[ppp_pkg::MagW-2:0], 1'b1};
        end else begin
          lane_d[s][l].rem = {lane_q[s-1][l].rem[ppp_pkg::MagW-2:0],
                              lane_q[s-1][l].mag[ppp_pkg::MagW-1]};
          lane_d[s][l].quo = {lane_q[s-1][l].quo[ppp_pkg::MagW-2:0], 1'b0};
        end
      end
      q_ext = {1'b0, lane_q[NStage-2][l].quo};
      sq = lane_q[NStage-2][l].neg ? -$signed({2'b0, q_ext}) : $signed({2'b0, q_ext});
      sq = sq + (ppp_pkg::MagW+3)'(lane_q[NStage-2][l].ctr);
      if (lane_q[NStage-2][l].zero) begin
        res_d[l] = lane_q[NStage-2][l].num_neg ? {1'b1, {(ppp_pkg::OutW-1){1'b0}}}
                                               : {1'b0, {(ppp_pkg::OutW-1){1'b1}}};
      end else if (sq > $signed((ppp_pkg::MagW+3)'(32'h7fffffff))) begin
        res_d[l] = {1'b0, {(ppp_pkg::OutW-1){1'b1}}};
      end else if (sq < -$signed((ppp_pkg::MagW+3)'(33'h080000000))) begin
        res_d[l] = {1'b1, {(ppp_pkg::OutW-1){1'b0}}};
      end else begin
        res_d[l] = ppp_pkg::OutW'(sq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NStage; s++) v_q[s] <= 1'b0;
    end else begin
      if (adv[0]) v_q[0] <= cam_valid_i;
      for (int s = 1; s < NStage; s++) begin
        if (adv[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && cam_valid_i) begin
      mi_q[0] <= '{cam: cam_i.cam_x, f: focal_i[ppp_pkg::CoordW-1:0],
                   c: principal_i[ppp_pkg::CoordW-1:0]};
      mi_q[1] <= '{cam: cam_i.cam_y, f: focal_i[2*ppp_pkg::CoordW-1:ppp_pkg::CoordW],
                   c: principal_i[2*ppp_pkg::CoordW-1:ppp_pkg::CoordW]};
      z_q <= cam_i.cam_z;
    end
    for (int s = 1; s < NStage - 1; s++) begin
      if (adv[s] && v_q[s-1]) lane_q[s] <= lane_d[s];
    end
    if (adv[NStage-1] && v_q[NStage-2]) begin
      res_q  <= res_d;
      zero_q <= lane_q[NStage-2][0].zero;
      zneg_q <= lane_q[NStage-2][0].z_neg;
    end
  end

  assign out_valid        = v_q[NStage-1];
  assign img_u_o          = res_q[0];
  assign img_v_o          = res_q[1];
  assign depth_zero_o     = zero_q;
  assign depth_negative_o = zneg_q;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(img_u_o) && $stable(img_v_o))
    else $error("result changed under stall");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(depth_zero_o && depth_negative_o))
    else $error("zero and negative depth together");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cam_stall_o |-> v_q[0] && out_stall)
    else $error("back stalled without cause");
`endif

endmodule
`default_nettype wire

// ===== rtl/pinhole_point_projection_unit.sv =====
// pipeline: 2 front stages, queue of 4 (readable the cycle after a write when empty), 57 back stages
// (operand, multiply, 54 restoring divide bit stages, rounding and saturation)
// throughput: one point per cycle while out_stall is low, set by the fully pipelined divider
// reset: asynchronous active low, registers return to identity rotation and
// zero translation, focal and principal point
//------------------------------------------------------------------------------
// pinhole_point_projection_unit
// world point to image coordinate projection with a configuration port
//------------------------------------------------------------------------------
`default_nettype none
module pinhole_point_projection_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  signed [ppp_pkg::CoordW-1:0]   px_i,
  input  wire  signed [ppp_pkg::CoordW-1:0]   py_i,
  input  wire  signed [ppp_pkg::CoordW-1:0]   pz_i,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [ppp_pkg::OutW-1:0]     img_u_o,
  output logic signed [ppp_pkg::OutW-1:0]     img_v_o,
  output logic                                depth_zero_o,
  output logic                                depth_negative_o,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [ppp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire  [ppp_pkg::CfgDataW-1:0]        cfg_data_i
);

  logic [ppp_pkg::RowW-1:0] row0_q, row1_q, row2_q;
  logic signed [ppp_pkg::CoordW-1:0] tx_q, ty_q, tz_q;
  logic [2*ppp_pkg::CoordW-1:0] focal_q, princ_q;
  logic cam_v, cam_s, q_v, q_s;
  ppp_pkg::cam_point_t cam_w, q_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q  <= ppp_pkg::RowW'(1) << ppp_pkg::RotFrac;
      row1_q  <= ppp_pkg::RowW'(1) << (ppp_pkg::RotFrac + ppp_pkg::EntryW);
      row2_q  <= ppp_pkg::RowW'(1) << (ppp_pkg::RotFrac + 2 * ppp_pkg::EntryW);
      tx_q    <= '0;
      ty_q    <= '0;
      tz_q    <= '0;
      focal_q <= '0;
      princ_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ppp_pkg::cfg_reg_e'(cfg_index_i))
        ppp_pkg::REG_ROT_ROW0:  row0_q  <= cfg_data_i[ppp_pkg::RowW-1:0];
        ppp_pkg::REG_ROT_ROW1:  row1_q  <= cfg_data_i[ppp_pkg::RowW-1:0];
        ppp_pkg::REG_ROT_ROW2:  row2_q  <= cfg_data_i[ppp_pkg::RowW-1:0];
        ppp_pkg::REG_TRANS_X:   tx_q    <= cfg_data_i[ppp_pkg::CoordW-1:0];
        ppp_pkg::REG_TRANS_Y:   ty_q    <= cfg_data_i[ppp_pkg::CoordW-1:0];
        ppp_pkg::REG_TRANS_Z:   tz_q    <= cfg_data_i[ppp_pkg::CoordW-1:0];
        ppp_pkg::REG_FOCAL:     focal_q <= cfg_data_i[2*ppp_pkg::CoordW-1:0];
        ppp_pkg::REG_PRINCIPAL: princ_q <= cfg_data_i[2*ppp_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .px_i, .py_i, .pz_i,
    .rot_row0_i(row0_q), .rot_row1_i(row1_q), .rot_row2_i(row2_q),
    .trans_x_i(tx_q), .trans_y_i(ty_q), .trans_z_i(tz_q),
    .cam_valid_o(cam_v), .cam_stall_i(cam_s), .cam_o(cam_w)
  );

  ppp_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(cam_v), .wr_stall_o(cam_s), .wr_data_i(cam_w),
    .rd_valid_o(q_v), .rd_stall_i(q_s), .rd_data_o(q_w)
  );

  ppp_back u_back (
    .clk_i, .rst_ni, .cam_valid_i(q_v), .cam_stall_o(q_s), .cam_i(q_w),
    .focal_i(focal_q), .principal_i(princ_q),
    .out_valid, .out_stall, .img_u_o, .img_v_o, .depth_zero_o, .depth_negative_o
  );

`ifndef NO_ASSERTIONS
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && depth_zero_o |-> !depth_negative_o)
    else $error("depth flags conflict");
  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && depth_zero_o |-> (img_u_o == 32'sh7fffffff || img_u_o == 32'sh80000000))
    else $error("zero depth not saturated");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(img_v_o))
    else $error("output changed under stall");
`endif

endmodule
`default_nettype wire

// ===== tb/ppp_checker.sv =====
//------------------------------------------------------------------------------
// ppp_checker
// watches the point and image channels of the projection unit, tracks the
// configuration writes, predicts each image word and compares it in order
//------------------------------------------------------------------------------
module ppp_checker
  import ppp_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid,
  input  wire                        in_stall,
  input  wire  signed [CoordW-1:0]   px_i,
  input  wire  signed [CoordW-1:0]   py_i,
  input  wire  signed [CoordW-1:0]   pz_i,
  input  wire                        out_valid,
  input  wire                        out_stall,
  input  wire  signed [OutW-1:0]     img_u_o,
  input  wire  signed [OutW-1:0]     img_v_o,
  input  wire                        depth_zero_o,
  input  wire                        depth_negative_o,
  input  wire                        cfg_valid,
  input  wire                        cfg_ready,
  input  wire  [CfgIdxW-1:0]         cfg_index_i,
  input  wire  [CfgDataW-1:0]        cfg_data_i,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;

  typedef struct {
    logic [OutW-1:0] u;
    logic [OutW-1:0] v;
    logic            zero;
    logic            neg;
  } image_point_t;

  logic [RowW-1:0]   rot_q [3];
  logic [CoordW-1:0] trans_q [3];
  logic [47:0]       focal_q;
  logic [47:0]       center_q;
  image_point_t      image_fifo [$];

  function automatic longint camera_axis(logic [RowW-1:0] row, longint p [3],
                                         logic [CoordW-1:0] t);
    longint acc;
    acc = 0;
    for (int j = 0; j < 3; j++) begin
      acc += longint'($signed(row[j*EntryW +: EntryW])) * p[j];
    end
    acc = (acc + (longint'(1) <<< (RotFrac - 1))) >>> RotFrac;
    return acc + longint'($signed(t));
  endfunction

  function automatic logic [OutW-1:0] image_coord(longint c, longint z,
                                                  logic [23:0] f, logic [23:0] ctr);
    longint          num;
    longint          r;
    longint unsigned an;
    longint unsigned az;
    longint unsigned q;
    num = longint'({40'd0, f}) * c;
    if (z == 0) begin
      r = (num >= 0) ? S32Max : S32Min;
    end else begin
      an = (num < 0) ? longint'(-num) : num;
      az = (z < 0) ? longint'(-z) : z;
      q = (an + az / 2) / az;
      r = (((num < 0) != (z < 0)) ? -longint'(q) : longint'(q)) + longint'({40'd0, ctr});
    end
    if (r > S32Max) r = S32Max;
    if (r < S32Min) r = S32Min;
    return r[OutW-1:0];
  endfunction

  function automatic image_point_t project_point(longint p [3]);
    image_point_t e;
    longint x, y, z;
    x = camera_axis(rot_q[0], p, trans_q[0]);
    y = camera_axis(rot_q[1], p, trans_q[1]);
    z = camera_axis(rot_q[2], p, trans_q[2]);
    e.u = image_coord(x, z, focal_q[23:0], center_q[23:0]);
    e.v = image_coord(y, z, focal_q[47:24], center_q[47:24]);
    e.zero = (z == 0);
    e.neg = (z < 0);
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    image_point_t e;
    longint       p [3];
    if (!rst_ni) begin
      rot_q[0] = 54'd65536;
      rot_q[1] = 54'd17179869184;
      rot_q[2] = 54'd4503599627370496;
      trans_q[0] = '0;
      trans_q[1] = '0;
      trans_q[2] = '0;
      focal_q = '0;
      center_q = '0;
      image_fifo.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (image_fifo.size() == 0) begin
          $display("%0t: image word with none expected: u=%h v=%h", $time, img_u_o, img_v_o);
          fail_count++;
        end else begin
          e = image_fifo.pop_front();
          if (img_u_o !== e.u) begin
            $display("%0t: img_u expected %h actual %h", $time, e.u, img_u_o);
            fail_count++;
          end
          if (img_v_o !== e.v) begin
            $display("%0t: img_v expected %h actual %h", $time, e.v, img_v_o);
            fail_count++;
          end
          if (depth_zero_o !== e.zero) begin
            $display("%0t: depth_zero expected %b actual %b", $time, e.zero, depth_zero_o);
            fail_count++;
          end
          if (depth_negative_o !== e.neg) begin
            $display("%0t: depth_negative expected %b actual %b", $time, e.neg,
                     depth_negative_o);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        p[0] = px_i;
        p[1] = py_i;
        p[2] = pz_i;
        image_fifo.push_back(project_point(p));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ROT_ROW0:  rot_q[0] = cfg_data_i[RowW-1:0];
          REG_ROT_ROW1:  rot_q[1] = cfg_data_i[RowW-1:0];
          REG_ROT_ROW2:  rot_q[2] = cfg_data_i[RowW-1:0];
          REG_TRANS_X:   trans_q[0] = cfg_data_i[CoordW-1:0];
          REG_TRANS_Y:   trans_q[1] = cfg_data_i[CoordW-1:0];
          REG_TRANS_Z:   trans_q[2] = cfg_data_i[CoordW-1:0];
          REG_FOCAL:     focal_q = cfg_data_i[47:0];
          REG_PRINCIPAL: center_q = cfg_data_i[47:0];
          default: ;
        endcase
      end
      pending = image_fifo.size();
    end
  end

endmodule

// ===== tb/tb_pinhole_point_projection_unit.sv =====
//------------------------------------------------------------------------------
// tb_pinhole_point_projection_unit
// drives world points and register writes into the projection unit with
// random gaps and output stalls; a checker module predicts every image word
//------------------------------------------------------------------------------
module tb_pinhole_point_projection_unit;
  import ppp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [CoordW-1:0]  px_i = '0;
  logic signed [CoordW-1:0]  py_i = '0;
  logic signed [CoordW-1:0]  pz_i = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [OutW-1:0]    img_u_o;
  logic signed [OutW-1:0]    img_v_o;
  logic                      depth_zero_o;
  logic                      depth_negative_o;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [CfgDataW-1:0]       cfg_data_i = '0;
  int                        fail_count;
  int                        pending;
  int                        cycle_count = 0;
  int                        points_sent = 0;
  bit                        calm = 1'b0;
  bit                        hold_req = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pinhole_point_projection_unit dut (.*);

  ppp_checker u_checker (.*);

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
      $display("tb_pinhole_point_projection_unit: FAIL");
      $finish;
    end
  end

  // output stalls: bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk_i);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                            logic [CoordW-1:0] z);
    if (!calm && !hold_req && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    px_i = x;
    py_i = y;
    pz_i = z;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
    points_sent++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_setup;
    write_reg(REG_ROT_ROW0, rand64());
    write_reg(REG_ROT_ROW1, rand64());
    write_reg(REG_ROT_ROW2, rand64());
    write_reg(REG_TRANS_X, rand64());
    write_reg(REG_TRANS_Y, rand64());
    write_reg(REG_TRANS_Z, rand64());
    write_reg(REG_FOCAL, rand64());
    write_reg(REG_PRINCIPAL, rand64());
  endtask

  task automatic random_points(int n);
    logic [CoordW-1:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          x = $signed(x[15:0]);
          y = $signed(y[15:0]);
          z = {8'd0, z[15:0]};
        end
        2: z = {20'd0, z[3:0]};
        default: begin
          x = $signed(x[11:0]);
          y = $signed(y[11:0]);
          z = $signed(z[11:0]);
        end
      endcase
      send_point(x, y, z);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: focal zero, so only depth flags, the center and saturation at zero depth show
    send_point(24'h000100, 24'h000200, 24'h000400);
    send_point(24'h000100, 24'h000200, 24'h000000);
    drain;

    write_reg(REG_FOCAL, {24'd400 << 8, 24'd500 << 8});
    write_reg(REG_PRINCIPAL, {24'd240 << 8, 24'd320 << 8});
    send_point(24'h7fffff, 24'h800000, 24'h000100);
    send_point(24'h800000, 24'h7fffff, 24'h7fffff);
    send_point(24'h7fffff, 24'h7fffff, 24'h800000);
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h000500, 24'hfffb00, 24'h000000);
    send_point(24'hfff000, 24'h001000, 24'hffff00);
    send_point(24'h000080, 24'hffff80, 24'h000001);
    send_point(24'hffffff, 24'h000001, 24'h000003);
    send_point(24'h012345, 24'hfedcba, 24'h002000);
    drain;

    // extreme settings
    write_reg(REG_ROT_ROW0, {3{18'h1ffff}});
    write_reg(REG_ROT_ROW1, {3{18'h20000}});
    write_reg(REG_ROT_ROW2, {3{18'h3ffff}});
    write_reg(REG_TRANS_X, 64'h7fffff);
    write_reg(REG_TRANS_Y, 64'h800000);
    write_reg(REG_TRANS_Z, 64'h7fffff);
    write_reg(REG_FOCAL, '1);
    write_reg(REG_PRINCIPAL, '1);
    send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h7fffff, 24'h800000, 24'h000000);
    send_point(24'h800000, 24'h7fffff, 24'h000001);
    drain;
    write_reg(REG_TRANS_X, 64'h800000);
    write_reg(REG_TRANS_Y, 64'h7fffff);
    write_reg(REG_TRANS_Z, 64'h800000);
    write_reg(REG_PRINCIPAL, '0);
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h800000, 24'h800000, 24'h7fffff);
    drain;

    for (int phase = 0; phase < 4; phase++) begin
      random_setup();
      if (phase == 1) hold_req = 1'b1;
      if (phase == 3) calm = 1'b1;
      random_points(200);
      drain;
    end

    repeat (100) @(negedge clk_i);
    $display("sent %0d points over reset, directed, extreme and four random settings,",
             points_sent);
    $display("with gaps, output stalls and one long output hold-off");
    if (fail_count == 0) begin
      $display("tb_pinhole_point_projection_unit: PASS");
    end else begin
      $display("tb_pinhole_point_projection_unit: FAIL");
    end
    $finish;
  end

endmodule
